### rtl/tlfr_pkg.sv
// Shared constants for the timed LED fade ramp.
package tlfr_pkg;

    // Brightness scale and fixed-point layout
    localparam int unsigned MAX_LEVEL   = 4095;
    localparam int unsigned LEVEL_W     = 12;        // integer level / PWM width
    localparam int unsigned FRAC_W      = 16;        // Q16 fraction bits
    localparam int unsigned LVL_FIX_W   = 30;        // signed Q13.16 level
    localparam int unsigned SUM_W       = 32;        // level plus or minus one step
    localparam int unsigned PCT_W       = 23;        // unsigned Q7.16 percent
    localparam int unsigned PCT_IN_W    = 7;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned DELAY_W     = 24;
    localparam int unsigned RAMP_W      = 16;

    localparam int unsigned PCT_SCALE   = 100;
    localparam logic [PCT_W-1:0] PCT_CAP     = 23'h7F_FFFF;
    localparam logic [PCT_W:0]   ONE_PCT     = 24'd65536;
    localparam logic [PCT_W-1:0] FULL_PCT    = 23'd6553600;   // 100 percent in Q16

    // Shared divider for the percent: dividend shift register width and iterations
    localparam int unsigned DVD_W       = 55;        // el*100 in Q16
    localparam int unsigned CNT_W       = 6;
    localparam int unsigned N_PCT       = 55;
    localparam int unsigned N_TGT       = 19;        // percent*MAX_LEVEL width
    localparam int unsigned STEP_W      = 29;        // level step width

    // Divide by 100 through a reciprocal: q = (x * DQ_MUL) >> DQ_SHIFT, exact for x < 2^23
    localparam int unsigned DQ_W        = 23;
    localparam int unsigned DQ_M_W      = 24;
    localparam logic [DQ_M_W-1:0] DQ_MUL = 24'd10737419;    // ceil(2^30 / 100)
    localparam int unsigned DQ_SHIFT    = 30;
    localparam int unsigned DQ_Q_W      = 17;
    localparam int unsigned REM_W       = 7;         // remainder of a divide by 100

    // Configuration register indexes
    localparam logic CFG_FULL_RAMP   = 1'b0;
    localparam logic CFG_PWM_CHANNEL = 1'b1;

    // Clamp and invert the integer part of the level for the PWM on-count
    function automatic logic [LEVEL_W-1:0] pwm_of_level(input logic [LVL_FIX_W-1:0] lvl);
        logic signed [LVL_FIX_W-FRAC_W-1:0] v;
        logic [LEVEL_W-1:0] res;
        v = $signed(lvl[LVL_FIX_W-1:FRAC_W]);
        if (v >= $signed((LVL_FIX_W-FRAC_W)'(MAX_LEVEL))) begin
            res = LEVEL_W'(MAX_LEVEL);
        end else if (v <= 0) begin
            res = '0;
        end else begin
            res = LEVEL_W'(MAX_LEVEL) - v[LEVEL_W-1:0];
        end
        return res;
    endfunction

endpackage

### rtl/timed_led_fade_ramp.sv
// Timed LED fade ramp: fade commands, millisecond ticks, one shared serial divider.
// Per item: a tick with no armed fade or before the start time goes straight to the output
// register; a fade command first takes its target; a running tick runs the divider (55
// steps, none with a zero ramp length), then the step states on a step; output can stall.
// Throughput: one item at a time; input is ready again in the cycle the result goes valid.
// Reset: aresetn synchronous active low; ramp state clears, full_ramp_ms goes to 1000.
module timed_led_fade_ramp import tlfr_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic                 cfg_index,
    input  logic [RAMP_W-1:0]    cfg_wdata,
    // input items
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_kind,
    input  logic [TIME_W-1:0]    s_now_ms,
    input  logic [PCT_IN_W-1:0]  s_brightness_percent,
    input  logic [DELAY_W-1:0]   s_delay_ms,
    // result items
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_pwm_write,
    output logic [LEVEL_W-1:0]   m_pwm_value,
    output logic                 m_fading,
    output logic                 m_going_up
);

    // Sequencer states
    localparam logic [3:0] ST_IDLE   = 4'd0;   // waiting for an item
    localparam logic [3:0] ST_DIV    = 4'd1;   // divider iterating on the percent
    localparam logic [3:0] ST_TARGET = 4'd2;   // command: take target, set direction
    localparam logic [3:0] ST_PCT    = 4'd3;   // tick: saturate percent quotient
    localparam logic [3:0] ST_GROWTH = 4'd4;   // tick: check growth, start step
    localparam logic [3:0] ST_QUO    = 4'd5;   // tick: growth / 100
    localparam logic [3:0] ST_REM    = 4'd6;   // tick: remainder part of the step
    localparam logic [3:0] ST_FRAC   = 4'd7;   // tick: assemble the step
    localparam logic [3:0] ST_APPLY  = 4'd8;   // tick: move level by the step
    localparam logic [3:0] ST_SETTLE = 4'd9;   // tick: store level, or snap to target and end ramp
    localparam logic [3:0] ST_FINISH = 4'd10;  // hand result to the output register

    // Ramp state
    logic [RAMP_W-1:0]    full_ramp_reg,  full_ramp_next;
    logic [LEVEL_W-1:0]   target_reg,     target_next;
    logic [LVL_FIX_W-1:0] level_reg,      level_next;
    logic [PCT_W-1:0]     last_pct_reg,   last_pct_next;
    logic [TIME_W-1:0]    start_reg,      start_next;
    logic                 planned_reg,    planned_next;
    logic                 active_reg,     active_next;
    logic                 rising_reg,     rising_next;

    // Sequencer
    logic [3:0]           state_reg,      state_next;
    logic                 wr_reg,         wr_next;

    // Shared divider
    logic [DVD_W-1:0]     dvd_reg,        dvd_next;
    logic [DVD_W-1:0]     quo_reg,        quo_next;
    logic [RAMP_W-1:0]    rem_reg,        rem_next;
    logic [RAMP_W-1:0]    den_reg,        den_next;
    logic [CNT_W-1:0]     cnt_reg,        cnt_next;

    // Divide-by-100 operand and step pieces
    logic [DQ_W-1:0]      dq_in_reg,      dq_in_next;
    logic [DQ_Q_W-1:0]    q100_reg,       q100_next;
    logic [STEP_W-1:0]    step_reg,       step_next;

    // Datapath scratch
    logic [PCT_W-1:0]     pct_reg,        pct_next;
    logic signed [SUM_W-1:0] sum_reg,     sum_next;

    // Output register
    logic                 m_valid_reg,    m_valid_next;
    logic                 m_wr_reg,       m_wr_next;
    logic [LEVEL_W-1:0]   m_value_reg,    m_value_next;
    logic                 m_fading_reg,   m_fading_next;
    logic                 m_up_reg,       m_up_next;

    // Combinational helpers
    logic [PCT_IN_W-1:0]  pct_sat;
    logic [N_TGT-1:0]     tgt_prod;
    logic [TIME_W-1:0]    elapsed;
    logic [TIME_W+6:0]    el_x100;
    logic signed [PCT_W:0] growth;
    logic [RAMP_W:0]      trial;
    logic                 trial_ge;
    logic [DQ_W+DQ_M_W-1:0] dq_prod;
    logic [DQ_Q_W-1:0]    dq_quo;
    logic [DQ_W-1:0]      hund_x;
    logic [DQ_W-1:0]      rem100;
    logic [DQ_W-1:0]      frac_prod;
    logic [STEP_W-1:0]    step_hi;
    logic signed [SUM_W-1:0] tgt_fix;
    logic signed [SUM_W-1:0] lvl_ext;
    logic signed [SUM_W-1:0] step_ext;
    logic                 snap;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);

    assign m_valid     = m_valid_reg;
    assign m_pwm_write = m_wr_reg;
    assign m_pwm_value = m_value_reg;
    assign m_fading    = m_fading_reg;
    assign m_going_up  = m_up_reg;

    // Command percent saturates at 100; target dividend is pct*MAX_LEVEL
    assign pct_sat  = (s_brightness_percent > PCT_IN_W'(PCT_SCALE)) ?
                      PCT_IN_W'(PCT_SCALE) : s_brightness_percent;
    assign tgt_prod = N_TGT'(pct_sat) * N_TGT'(MAX_LEVEL);

    // Elapsed time wraps modulo 2^32, as does the start time
    assign elapsed  = s_now_ms - start_reg;
    assign el_x100  = (TIME_W+7)'(elapsed) * (TIME_W+7)'(PCT_SCALE);

    // Percent growth since the last step; negative when time ran backwards
    assign growth    = $signed({1'b0, pct_reg}) - $signed({1'b0, last_pct_reg});

    // One restoring-division step per cycle
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_ge = (trial >= {1'b0, den_reg});

    // Divide by 100 by reciprocal multiply on a registered operand
    assign dq_prod  = (DQ_W+DQ_M_W)'(dq_in_reg) * (DQ_W+DQ_M_W)'(DQ_MUL);
    assign dq_quo   = dq_prod[DQ_SHIFT +: DQ_Q_W];

    // step = (growth/100)*MAX + ((growth%100)*MAX)/100
    assign hund_x    = DQ_W'(q100_reg) * DQ_W'(PCT_SCALE);
    assign rem100    = dq_in_reg - hund_x;
    assign frac_prod = DQ_W'(rem100[REM_W-1:0]) * DQ_W'(MAX_LEVEL);
    assign step_hi   = STEP_W'(q100_reg) * STEP_W'(MAX_LEVEL);

    assign tgt_fix  = $signed({{(SUM_W-LEVEL_W-FRAC_W){1'b0}}, target_reg, {FRAC_W{1'b0}}});
    assign lvl_ext  = $signed({{(SUM_W-LVL_FIX_W){level_reg[LVL_FIX_W-1]}}, level_reg});
    assign step_ext = $signed({{(SUM_W-STEP_W){1'b0}}, step_reg});

    // Ramp ends at 100 percent or once the level reaches the target
    assign snap = (pct_reg >= FULL_PCT) ||
                  ( rising_reg && (sum_reg >= tgt_fix)) ||
                  (!rising_reg && (sum_reg <= tgt_fix));

    always_comb begin
        full_ramp_next = full_ramp_reg;
        target_next    = target_reg;
        level_next     = level_reg;
        last_pct_next  = last_pct_reg;
        start_next     = start_reg;
        planned_next   = planned_reg;
        active_next    = active_reg;
        rising_next    = rising_reg;
        state_next     = state_reg;
        wr_next        = wr_reg;
        dvd_next       = dvd_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        den_next       = den_reg;
        cnt_next       = cnt_reg;
        dq_in_next     = dq_in_reg;
        q100_next      = q100_reg;
        step_next      = step_reg;
        pct_next       = pct_reg;
        sum_next       = sum_reg;
        m_valid_next   = m_valid_reg;
        m_wr_next      = m_wr_reg;
        m_value_next   = m_value_reg;
        m_fading_next  = m_fading_reg;
        m_up_next      = m_up_reg;

        // pwm_channel is held off-block; only the ramp length affects results
        if (cfg_valid && (cfg_index == CFG_FULL_RAMP)) begin
            full_ramp_next = cfg_wdata;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    wr_next = 1'b0;
                    rem_next = '0;
                    quo_next = '0;
                    if (s_kind) begin
                        // fade command: arm, then pct*MAX / 100
                        start_next    = s_now_ms + TIME_W'(s_delay_ms);
                        planned_next  = 1'b1;
                        last_pct_next = '0;
                        dq_in_next    = DQ_W'(tgt_prod);
                        state_next    = ST_TARGET;
                    end else if (planned_reg && (s_now_ms >= start_reg)) begin
                        active_next = 1'b1;
                        if (full_ramp_reg == '0) begin
                            pct_next   = PCT_CAP;
                            state_next = ST_GROWTH;
                        end else begin
                            dvd_next   = {el_x100, {FRAC_W{1'b0}}};
                            den_next   = full_ramp_reg;
                            cnt_next   = CNT_W'(N_PCT);
                            state_next = ST_DIV;
                        end
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_DIV: begin
                rem_next = trial_ge ? RAMP_W'(trial - {1'b0, den_reg}) : trial[RAMP_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                quo_next = {quo_reg[DVD_W-2:0], trial_ge};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_PCT;
                end
            end
            ST_TARGET: begin
                target_next = dq_quo[LEVEL_W-1:0];
                rising_next = $signed({{(SUM_W-LEVEL_W-FRAC_W){1'b0}},
                                       dq_quo[LEVEL_W-1:0], {FRAC_W{1'b0}}}) > lvl_ext;
                state_next  = ST_FINISH;
            end
            ST_PCT: begin
                pct_next   = (quo_reg[DVD_W-1:PCT_W] != '0) ? PCT_CAP : quo_reg[PCT_W-1:0];
                state_next = ST_GROWTH;
            end
            ST_GROWTH: begin
                if (growth >= $signed(ONE_PCT)) begin
                    last_pct_next = pct_reg;
                    dq_in_next    = DQ_W'(growth[PCT_W-1:0]);
                    state_next    = ST_QUO;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_QUO: begin
                q100_next  = dq_quo;
                state_next = ST_REM;
            end
            ST_REM: begin
                step_next  = step_hi;
                dq_in_next = frac_prod;
                state_next = ST_FRAC;
            end
            ST_FRAC: begin
                step_next  = step_reg + STEP_W'(dq_quo);
                state_next = ST_APPLY;
            end
            ST_APPLY: begin
                sum_next   = rising_reg ? (lvl_ext + step_ext) : (lvl_ext - step_ext);
                state_next = ST_SETTLE;
            end
            ST_SETTLE: begin
                if (snap) begin
                    level_next   = tgt_fix[LVL_FIX_W-1:0];
                    planned_next = 1'b0;
                    active_next  = 1'b0;
                    start_next   = '0;
                end else begin
                    level_next = sum_reg[LVL_FIX_W-1:0];
                end
                wr_next    = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // output register frees up, or is taken this cycle
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_wr_next     = wr_reg;
                    m_value_next  = wr_reg ? pwm_of_level(level_reg) : '0;
                    m_fading_next = active_reg;
                    m_up_next     = rising_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_ramp_reg <= RAMP_W'(1000);
            target_reg    <= '0;
            level_reg     <= '0;
            last_pct_reg  <= '0;
            start_reg     <= '0;
            planned_reg   <= 1'b0;
            active_reg    <= 1'b0;
            rising_reg    <= 1'b0;
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
        end else begin
            full_ramp_reg <= full_ramp_next;
            target_reg    <= target_next;
            level_reg     <= level_next;
            last_pct_reg  <= last_pct_next;
            start_reg     <= start_next;
            planned_reg   <= planned_next;
            active_reg    <= active_next;
            rising_reg    <= rising_next;
            state_reg     <= state_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Datapath and payload registers: no reset needed
    always_ff @(posedge aclk) begin
        wr_reg       <= wr_next;
        dvd_reg      <= dvd_next;
        quo_reg      <= quo_next;
        rem_reg      <= rem_next;
        den_reg      <= den_next;
        cnt_reg      <= cnt_next;
        dq_in_reg    <= dq_in_next;
        q100_reg     <= q100_next;
        step_reg     <= step_next;
        pct_reg      <= pct_next;
        sum_reg      <= sum_next;
        m_wr_reg     <= m_wr_next;
        m_value_reg  <= m_value_next;
        m_fading_reg <= m_fading_next;
        m_up_reg     <= m_up_next;
    end

endmodule

### verif/tb_top.sv
// Self-checking testbench for the timed LED fade ramp: directed and random stimulus, scoreboard, predictor.
module tb_top import tlfr_pkg::*; ();

    // Item kinds on s_kind
    localparam bit KIND_TICK = 1'b0;
    localparam bit KIND_FADE = 1'b1;

    // Q16 helpers for the predictor
    localparam longint ONE_Q16     = 65536;
    localparam longint PCT_SAT_Q16 = 64'h7F_FFFF;

    // Watchdog: the run fails if it is still going at this time
    localparam longint RUN_LIMIT = 64'd20_000_000;

    typedef struct packed {
        bit                    kind;
        bit [TIME_W-1:0]       now_ms;
        bit [PCT_IN_W-1:0]     pct;
        bit [DELAY_W-1:0]      delay_ms;
    } led_event_t;

    typedef struct packed {
        bit                    pwm_write;
        bit [LEVEL_W-1:0]      pwm_value;
        bit                    fading;
        bit                    going_up;
    } pwm_result_t;

    // DUT pins; every input is known from time zero
    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = CFG_FULL_RAMP;
    logic [RAMP_W-1:0]    cfg_wdata = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_kind = KIND_TICK;
    logic [TIME_W-1:0]    s_now_ms = '0;
    logic [PCT_IN_W-1:0]  s_brightness_percent = '0;
    logic [DELAY_W-1:0]   s_delay_ms = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_pwm_write;
    logic [LEVEL_W-1:0]   m_pwm_value;
    logic                 m_fading;
    logic                 m_going_up;

    timed_led_fade_ramp dut (.*);

    always #10 aclk = ~aclk;

    // Predictor copy of the configuration (reset values)
    bit [RAMP_W-1:0]  ramp_len_ms = 16'd1000;
    bit [3:0]         pwm_chan = 4'd0;     // held only, never affects a result

    // Predictor copy of the ramp state (reset values)
    bit [LEVEL_W-1:0] tgt_lvl = '0;
    longint           lvl_q16 = 0;         // signed Q13.16 level
    longint           last_pct_q16 = 0;    // unsigned Q7.16 percent at last step
    bit [TIME_W-1:0]  start_at_ms = '0;
    bit               armed = 1'b0;
    bit               ramping = 1'b0;
    bit               going_up_q = 1'b0;

    led_event_t   led_events_q[$];   // items waiting for the driver
    pwm_result_t  pwm_due_q[$];      // predicted results, oldest first
    led_event_t   cur_event;         // item currently on the s_ pins
    bit           s_fire = 1'b0;     // s_ handshake seen at the last rising edge
    int           pushed = 0;        // items queued so far
    int           in_count = 0;      // items accepted so far
    int           err_cnt = 0;
    bit [31:0]    wall_ms = 32'd20000;

    // Work out the result of one accepted item and advance the predicted state
    function automatic pwm_result_t next_pwm_result(input led_event_t ev);
        pwm_result_t        res;
        bit [PCT_IN_W-1:0]  pct;
        bit [31:0]          since_start;
        bit [63:0]          pct_raw;
        longint             pct_q16;
        longint             growth;
        longint             lvl_step;
        longint             tgt_q16;
        longint             whole;
        res = '0;
        if (ev.kind == KIND_FADE) begin
            // percent above 100 saturates
            pct = (ev.pct > 7'd100) ? 7'd100 : ev.pct;
            tgt_lvl = LEVEL_W'((int'(pct) * int'(MAX_LEVEL)) / 100);
            going_up_q = (longint'(tgt_lvl) * ONE_Q16) > lvl_q16;
            start_at_ms = ev.now_ms + ev.delay_ms;     // wraps mod 2^32
            armed = 1'b1;
            last_pct_q16 = 0;
            // ramping is left alone: only a finished ramp clears it
        end else if (armed && ev.now_ms >= start_at_ms) begin
            ramping = 1'b1;
            if (ramp_len_ms == 0) begin
                pct_q16 = PCT_SAT_Q16;
            end else begin
                since_start = ev.now_ms - start_at_ms;
                pct_raw = 64'(since_start) * 100 * 65536 / 64'(ramp_len_ms);
                pct_q16 = (pct_raw > 64'(PCT_SAT_Q16)) ? PCT_SAT_Q16 : longint'(pct_raw);
            end
            growth = pct_q16 - last_pct_q16;
            // less than one percent of growth (or time going back): no step
            if (growth >= ONE_Q16) begin
                lvl_step = growth * longint'(MAX_LEVEL) / 100;
                tgt_q16 = longint'(tgt_lvl) * ONE_Q16;
                lvl_q16 = going_up_q ? lvl_q16 + lvl_step : lvl_q16 - lvl_step;
                last_pct_q16 = pct_q16;
                if (pct_q16 >= 100 * ONE_Q16 || (going_up_q && lvl_q16 >= tgt_q16) ||
                    (!going_up_q && lvl_q16 <= tgt_q16)) begin
                    lvl_q16 = tgt_q16;
                    armed = 1'b0;
                    ramping = 1'b0;
                    start_at_ms = '0;
                end
                // clamp, then invert anything strictly inside the range
                whole = lvl_q16 / ONE_Q16;
                res.pwm_write = 1'b1;
                if (whole >= longint'(MAX_LEVEL)) begin
                    res.pwm_value = LEVEL_W'(MAX_LEVEL);
                end else if (whole <= 0) begin
                    res.pwm_value = '0;
                end else begin
                    res.pwm_value = LEVEL_W'(longint'(MAX_LEVEL) - whole);
                end
            end
        end
        res.fading = ramping;
        res.going_up = going_up_q;
        return res;
    endfunction

    task automatic queue_item(input bit kind, input bit [31:0] now,
                              input bit [6:0] pct, input bit [23:0] dly);
        led_events_q.push_back('{kind, now, pct, dly});
        pushed++;
    endtask

    // Ticks carry junk in the command-only fields; the block must ignore it
    task automatic queue_tick(input bit [31:0] now);
        queue_item(KIND_TICK, now, 7'($urandom_range(0, 127)), 24'($urandom));
    endtask

    // Fully random items, broken sequences included
    task automatic queue_noise();
        repeat ($urandom_range(1, 3)) begin
            queue_item(($urandom_range(0, 3) == 0) ? KIND_FADE : KIND_TICK, $urandom,
                       7'($urandom_range(0, 127)), 24'($urandom));
        end
    endtask

    // One well-formed fade: command, a few early ticks, then ticks walking through
    // the ramp with random strides; sometimes time steps back or a new command
    // lands mid-ramp.
    task automatic queue_fade_run();
        bit [31:0]    t_cmd;
        bit [31:0]    t_start;
        bit [31:0]    t_now;
        bit [23:0]    dly;
        bit [6:0]     pct;
        int unsigned  stride;
        int unsigned  span;
        int           n;
        stride = ramp_len_ms / 8 + 2;
        span = ramp_len_ms + ramp_len_ms / 4 + 2;
        // now and then park the clock just below the 32-bit wrap
        if ($urandom_range(0, 15) == 0)
            wall_ms = 32'hFFFF_FFFF - $urandom_range(0, span * 2);
        t_cmd = wall_ms;
        case ($urandom_range(0, 9))
            0, 1: dly = '0;
            2: dly = 24'($urandom);
            3: dly = 24'hFF_FFFF - 24'($urandom_range(0, 50));
            default: dly = 24'($urandom_range(0, ramp_len_ms / 2 + 5));
        endcase
        pct = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(101, 127))
                                          : 7'($urandom_range(0, 100));
        queue_item(KIND_FADE, t_cmd, pct, dly);
        t_start = t_cmd + dly;
        repeat ($urandom_range(0, 2)) queue_tick(t_cmd + $urandom_range(0, dly));
        t_now = t_start + ($urandom_range(0, 1) ? 0 : $urandom_range(0, stride));
        n = 0;
        while (t_now - t_start <= span && n < 48) begin
            case ($urandom_range(0, 19))
                0: queue_tick(t_now - $urandom_range(0, stride));
                1: begin
                    dly = 24'($urandom_range(0, stride));
                    queue_item(KIND_FADE, t_now, 7'($urandom_range(0, 100)), dly);
                    t_start = t_now + dly;
                    t_now = t_start;
                end
                default: queue_tick(t_now);
            endcase
            t_now += $urandom_range(0, stride);
            n++;
        end
        wall_ms = t_now + $urandom_range(1, 1000);
    endtask

    // Hold off until every queued item went in and every result came back
    task automatic drain();
        do @(negedge aclk); while (in_count != pushed || pwm_due_q.size() != 0);
    endtask

    task automatic cfg_write(input logic idx, input logic [RAMP_W-1:0] data);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_wdata <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == CFG_FULL_RAMP)
            ramp_len_ms = data;
        else
            pwm_chan = data[3:0];
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            err_cnt++;
            if (err_cnt <= 40)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Input side, rising edge: note the handshake and predict the accepted item
    always @(posedge aclk) begin
        s_fire <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            pwm_due_q.push_back(next_pwm_result(cur_event));
            in_count++;
        end
    end

    // Driver, falling edge. Idle mix by progress: sender 34 / receiver 48,
    // then swapped, then no idling at all.
    always @(negedge aclk) begin
        if (!(s_valid && !s_fire)) begin
            if (led_events_q.size() != 0 && $urandom_range(0, 99) >=
                ((in_count < 460) ? 34 : (in_count < 920) ? 48 : 0)) begin
                cur_event = led_events_q.pop_front();
                s_kind <= cur_event.kind;
                s_now_ms <= cur_event.now_ms;
                s_brightness_percent <= cur_event.pct;
                s_delay_ms <= cur_event.delay_ms;
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >=
                    ((in_count < 460) ? 48 : (in_count < 920) ? 34 : 0));
    end

    // Monitor: every accepted result against the oldest prediction
    always @(posedge aclk) begin
        pwm_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pwm_due_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 40)
                    $display("%0t: unexpected result, expected none, got write=%0d value=%0d",
                             $time, m_pwm_write, m_pwm_value);
            end else begin
                want = pwm_due_q.pop_front();
                check_field("pwm_write", want.pwm_write, m_pwm_write);
                check_field("pwm_value", want.pwm_value, m_pwm_value);
                check_field("fading", want.fading, m_fading);
                check_field("going_up", want.going_up, m_going_up);
            end
        end
    end

    initial begin
        #(RUN_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus: reset, directed item list, then six configuration phases
    initial begin
        bit [RAMP_W-1:0]  ramp_plan [6];
        bit [3:0]         chan_plan [6];
        int               goal;
        bit               held;
        ramp_plan = '{16'd200, 16'd1, 16'hFFFF, 16'd0, 16'd1000, 16'd1000};
        chan_plan = '{4'd5, 4'd15, 4'd0, 4'd10, 4'd3, 4'd0};
        ramp_plan[4] = 16'($urandom_range(2, 3000));
        chan_plan[4] = 4'($urandom);
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed, default 1000 ms ramp
        queue_tick(32'd0);                        // nothing armed: no write
        queue_tick(32'hFFFF_FFFF);
        queue_item(KIND_FADE, 32'd1000, 7'd100, 24'd0);
        queue_tick(32'd1000);                     // started, zero percent
        queue_tick(32'd1005);                     // half a percent: no step
        queue_tick(32'd1010);                     // first step
        queue_tick(32'd1003);                     // clock went back
        queue_tick(32'd1500);
        queue_item(KIND_FADE, 32'd1500, 7'd127, 24'd0);   // over 100, mid-ramp
        queue_tick(32'd3000);                     // percent saturates, snap to full
        queue_item(KIND_FADE, 32'd3000, 7'd0, 24'd100);   // fade down
        queue_tick(32'd3050);                     // before start
        queue_tick(32'd3100);
        queue_tick(32'd3600);                     // level strictly inside: inverted
        queue_tick(32'd5000);                     // snap to zero
        queue_item(KIND_FADE, 32'hFFFF_FF00, 7'd50, 24'h200);  // start time wraps
        queue_tick(32'hFFFF_FF80);
        queue_item(KIND_FADE, 32'd10, 7'd1, 24'hFF_FFFF);      // longest delay
        queue_tick(32'h0100_0010);
        queue_tick(32'hFFFF_FFFF);
        queue_tick(32'hFFFF_FFFF);                // ramp done, nothing armed
        drain();

        for (int p = 0; p < 6; p++) begin
            // block is idle here; zero ramp length comes up in phase 3
            cfg_write(CFG_FULL_RAMP, ramp_plan[p]);
            cfg_write(CFG_PWM_CHANNEL, {12'($urandom), chan_plan[p]});
            goal = pushed + 225;
            held = 1'b0;
            while (pushed < goal) begin
                if ($urandom_range(0, 7) == 0)
                    queue_noise();
                else
                    queue_fade_run();
                // once per phase the sender waits for the block to empty out
                if (!held && pushed >= goal - 110) begin
                    drain();
                    held = 1'b1;
                end
            end
            drain();
        end

        repeat (120) @(negedge aclk);
        if (err_cnt == 0 && pwm_due_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
